// ===== design/rtkp_pkg.sv =====
`default_nettype none

package rtkp_pkg;

  localparam int unsigned CAPACITY = 16;

  localparam int unsigned COST_W   = 32;
  localparam int unsigned TAG_W    = 8;
  localparam int unsigned RIDX_W   = 4;
  localparam int unsigned RANK_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned RANK_EXT_W = (IDX_W > RANK_W) ? IDX_W : RANK_W;
  localparam int unsigned CNT_EXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned RIDX_EXT_W = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;
  localparam int unsigned CMP_W      = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_READ
  } state_e;

  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic [TAG_W-1:0]         tag;
  } entry_t;

  typedef struct packed {
    logic                     accepted;
    logic [RANK_W-1:0]        insert_rank;
    logic                     evicted_valid;
    logic [TAG_W-1:0]         evicted_tag;
    logic                     read_valid;
    logic signed [COST_W-1:0] read_cost;
    logic [TAG_W-1:0]         read_tag;
    logic [COUNT_W-1:0]       entry_count;
    logic                     pool_full;
  } result_t;

endpackage

`default_nettype wire

// ===== design/rtkp_if.sv =====
`default_nettype none

interface rtkp_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     opcode;
  logic signed [rtkp_pkg::COST_W-1:0]       offer_cost;
  logic [rtkp_pkg::TAG_W-1:0]               offer_tag;
  logic [rtkp_pkg::RIDX_W-1:0]              read_index;

  modport source (output valid, opcode, offer_cost, offer_tag, read_index, input ready);
  modport sink   (input valid, opcode, offer_cost, offer_tag, read_index, output ready);
endinterface

interface rtkp_out_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     accepted;
  logic [rtkp_pkg::RANK_W-1:0]              insert_rank;
  logic                                     evicted_valid;
  logic [rtkp_pkg::TAG_W-1:0]               evicted_tag;
  logic                                     read_valid;
  logic signed [rtkp_pkg::COST_W-1:0]       read_cost;
  logic [rtkp_pkg::TAG_W-1:0]               read_tag;
  logic [rtkp_pkg::COUNT_W-1:0]             entry_count;
  logic                                     pool_full;

  modport source (output valid, accepted, insert_rank, evicted_valid, evicted_tag,
                  read_valid, read_cost, read_tag, entry_count, pool_full,
                  input ready);
  modport sink   (input valid, accepted, insert_rank, evicted_valid, evicted_tag,
                  read_valid, read_cost, read_tag, entry_count, pool_full,
                  output ready);
endinterface

`default_nettype wire

// ===== design/ranked_topk_pool_core.sv =====
`default_nettype none
// channel   dir  beat
// in_i      in   opcode, offer_cost, offer_tag, read_index
// out_o     out  accepted, insert_rank, evicted_valid, evicted_tag, read_valid,
//                read_cost, read_tag, entry_count, pool_full
//
// one item at a time; the pool lives in one memory with a registered read port
// offer: the entries with lower cost are walked from the tail one per cycle,
// then the offer is written at its rank; a read finishes from ST_READ
// reset clears the state, entry count, output valid and scan flags; no clearing pass over the memory
// a new beat is taken while the previous result still waits in the output
// register; a finished item holds until that register is free

module ranked_topk_pool_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  rtkp_in_if.sink      in_i,
  rtkp_out_if.source   out_o
);

  localparam int unsigned IDX_W = rtkp_pkg::IDX_W;
  localparam int unsigned CNT_W = rtkp_pkg::CNT_W;

  rtkp_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   rank_q, rank_d;
  logic               first_q, first_d;
  logic               ev_valid_q, ev_valid_d;
  logic [rtkp_pkg::TAG_W-1:0] ev_tag_q, ev_tag_d;

  logic                               op_q;
  logic signed [rtkp_pkg::COST_W-1:0] cost_q;
  logic [rtkp_pkg::TAG_W-1:0]         tag_q;
  logic [rtkp_pkg::RIDX_W-1:0]        ridx_q;

  rtkp_pkg::entry_t mem_q [rtkp_pkg::CAPACITY];
  rtkp_pkg::entry_t rd_data_q;
  rtkp_pkg::entry_t wr_data;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  logic               out_valid_q;
  rtkp_pkg::result_t  res_q, res_d;
  logic               finish;
  logic               out_free;
  logic               in_beat;

  logic [rtkp_pkg::RIDX_EXT_W-1:0] ridx_ext;
  logic [IDX_W-1:0]                ridx_addr;
  logic                            ridx_ok;
  logic                            in_ridx_ok;
  logic [rtkp_pkg::RIDX_EXT_W-1:0] in_ridx_ext;
  logic                            offer_gt;
  logic [rtkp_pkg::RANK_EXT_W-1:0] rank_ext;
  logic [rtkp_pkg::CNT_EXT_W-1:0]  count_ext;
  logic [CNT_W-1:0]                count_acc;
  logic [IDX_W-1:0]                fin_rank;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == rtkp_pkg::ST_IDLE);
  assign in_beat = in_i.valid && in_i.ready;

  assign ridx_ext    = rtkp_pkg::RIDX_EXT_W'(ridx_q);
  assign ridx_addr   = ridx_ext[IDX_W-1:0];
  assign ridx_ok     = rtkp_pkg::CMP_W'(ridx_q) < rtkp_pkg::CMP_W'(count_q);
  assign in_ridx_ext = rtkp_pkg::RIDX_EXT_W'(in_i.read_index);
  assign in_ridx_ok  = rtkp_pkg::CMP_W'(in_i.read_index) < rtkp_pkg::CMP_W'(count_q);
  assign offer_gt    = $signed(cost_q) > $signed(rd_data_q.cost);

  // count after an accepted offer
  assign count_acc = ev_valid_q ? count_q : CNT_W'(count_q + 1'b1);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    rank_d     = rank_q;
    first_d    = first_q;
    ev_valid_d = ev_valid_q;
    ev_tag_d   = ev_tag_q;
    rd_en      = 1'b0;
    rd_addr    = idx_q;
    wr_en      = 1'b0;
    wr_addr    = idx_q;
    wr_data    = rd_data_q;
    finish     = 1'b0;
    fin_rank   = '0;
    res_d      = '0;
    rank_ext   = '0;
    count_ext  = '0;

    case (state_q)
      rtkp_pkg::ST_IDLE: begin
        if (in_beat) begin
          ev_valid_d = 1'b0;
          ev_tag_d   = '0;
          if (in_i.opcode == rtkp_pkg::OP_READ) begin
            rd_en   = in_ridx_ok;
            rd_addr = in_ridx_ext[IDX_W-1:0];
            state_d = rtkp_pkg::ST_READ;
          end else if (count_q == '0) begin
            rank_d  = '0;
            state_d = rtkp_pkg::ST_INSERT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(count_q - 1'b1);
            idx_d   = IDX_W'(count_q - 1'b1);
            first_d = 1'b1;
            state_d = rtkp_pkg::ST_SCAN;
          end
        end
      end

      rtkp_pkg::ST_SCAN: begin
        if (offer_gt) begin
          // entry moves one place down, or drops off the tail
          if (idx_q == IDX_W'(rtkp_pkg::CAPACITY - 1)) begin
            ev_valid_d = 1'b1;
            ev_tag_d   = rd_data_q.tag;
          end else begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(idx_q + 1'b1);
            wr_data = rd_data_q;
          end
          first_d = 1'b0;
          if (idx_q == '0) begin
            rank_d  = '0;
            state_d = rtkp_pkg::ST_INSERT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(idx_q - 1'b1);
            idx_d   = IDX_W'(idx_q - 1'b1);
          end
        end else if (first_q) begin
          // nothing lower than the offer: reject
          if (out_free) begin
            finish = 1'b1;
            count_ext = rtkp_pkg::CNT_EXT_W'(count_q);
            res_d.entry_count = count_ext[rtkp_pkg::COUNT_W-1:0];
            res_d.pool_full   = (count_q == CNT_W'(rtkp_pkg::CAPACITY));
            state_d = rtkp_pkg::ST_IDLE;
          end
        end else begin
          fin_rank = IDX_W'(idx_q + 1'b1);
          wr_en    = 1'b1;
          wr_addr  = fin_rank;
          wr_data.cost = cost_q;
          wr_data.tag  = tag_q;
          if (out_free) begin
            finish  = 1'b1;
            count_d = count_acc;
            state_d = rtkp_pkg::ST_IDLE;
          end
        end
      end

      rtkp_pkg::ST_INSERT: begin
        fin_rank = rank_q;
        wr_en    = 1'b1;
        wr_addr  = rank_q;
        wr_data.cost = cost_q;
        wr_data.tag  = tag_q;
        if (out_free) begin
          finish  = 1'b1;
          count_d = count_acc;
          state_d = rtkp_pkg::ST_IDLE;
        end
      end

      rtkp_pkg::ST_READ: begin
        rd_addr = ridx_addr;
        if (out_free) begin
          finish = 1'b1;
          count_ext = rtkp_pkg::CNT_EXT_W'(count_q);
          res_d.entry_count = count_ext[rtkp_pkg::COUNT_W-1:0];
          res_d.pool_full   = (count_q == CNT_W'(rtkp_pkg::CAPACITY));
          res_d.read_valid  = ridx_ok;
          res_d.read_cost   = ridx_ok ? rd_data_q.cost : '0;
          res_d.read_tag    = ridx_ok ? rd_data_q.tag : '0;
          state_d = rtkp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rtkp_pkg::ST_IDLE;
      end
    endcase

    // accepted offer result
    if (finish && (op_q == rtkp_pkg::OP_OFFER) && (state_q != rtkp_pkg::ST_SCAN || !first_q
        || offer_gt)) begin
      rank_ext  = rtkp_pkg::RANK_EXT_W'(fin_rank);
      count_ext = rtkp_pkg::CNT_EXT_W'(count_acc);
      res_d.accepted      = 1'b1;
      res_d.insert_rank   = rank_ext[rtkp_pkg::RANK_W-1:0];
      res_d.evicted_valid = ev_valid_q;
      res_d.evicted_tag   = ev_valid_q ? ev_tag_q : '0;
      res_d.entry_count   = count_ext[rtkp_pkg::COUNT_W-1:0];
      res_d.pool_full     = (count_acc == CNT_W'(rtkp_pkg::CAPACITY));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtkp_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
      ev_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      first_q    <= first_d;
      ev_valid_q <= ev_valid_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    rank_q   <= rank_d;
    ev_tag_q <= ev_tag_d;
    if (in_beat) begin
      op_q   <= in_i.opcode;
      cost_q <= in_i.offer_cost;
      tag_q  <= in_i.offer_tag;
      ridx_q <= in_i.read_index;
    end
    if (finish) begin
      res_q <= res_d;
    end
  end

  // pool memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.accepted      = res_q.accepted;
  assign out_o.insert_rank   = res_q.insert_rank;
  assign out_o.evicted_valid = res_q.evicted_valid;
  assign out_o.evicted_tag   = res_q.evicted_tag;
  assign out_o.read_valid    = res_q.read_valid;
  assign out_o.read_cost     = res_q.read_cost;
  assign out_o.read_tag      = res_q.read_tag;
  assign out_o.entry_count   = res_q.entry_count;
  assign out_o.pool_full     = res_q.pool_full;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(rtkp_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rtkp_pkg::ST_SCAN) |-> (CNT_W'(idx_q) < count_q))
    else $error("scan index outside held entries");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.evicted_valid) |-> (out_o.accepted && out_o.pool_full))
    else $error("eviction without a full pool");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(finish) && (count_q == $past(count_q) + 1'b1)))
    else $error("entry count changed by other than one accepted offer");

endmodule

`default_nettype wire
